>>> rtl/core/i2cee_pkg.sv
`default_nettype none

package i2cee_pkg;

  // Default EEPROM address width
  localparam int unsigned ADDRESS_BITS_DEF = 16;

  // Field widths of one tick item and one result item
  localparam int unsigned MEM_ADDR_W = 16;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_TWO_BYTE_ADDRESS = 2'd0;
  localparam reg_index_t REG_DEVICE_CODE      = 2'd1;
  localparam reg_index_t REG_ACK_TIMEOUT      = 2'd2;
  localparam reg_index_t REG_WRITE_WAIT_TICKS = 2'd3;

  // Register reset values
  localparam logic       TWO_BYTE_ADDRESS_RST = 1'b0;
  localparam logic [6:0] DEVICE_CODE_RST      = 7'h50;
  localparam logic [7:0] ACK_TIMEOUT_RST      = 8'd250;
  localparam logic [15:0] WRITE_WAIT_RST      = 16'd3000;

  // Tick kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_TICK  = 2'd0;
  localparam kind_t KIND_WRITE = 2'd1;
  localparam kind_t KIND_READ  = 2'd2;

endpackage

`default_nettype wire

>>> rtl/core/i2c_eeprom_byte_master_unit.sv
`default_nettype none

// I2C master for a single-byte write or random read on a 24Cxx-style EEPROM.
// Each transfer on the s_ channel is one quarter-bit tick: tuser carries the
// kind (plain tick, write request, read request) and tdata carries the
// address, the byte to write and the sampled SDA level. Each tick produces
// exactly one result on the m_ channel with the SCL level, the SDA pull-down,
// busy, a one-tick done pulse, the read byte and the acknowledge error flag.
// The result of a tick is presented the cycle after the tick is accepted;
// the sequencer takes one tick per clock, so ticks may stream back to back.
// The result register is refilled in the same cycle it is taken, so s_tready
// drops only while a result waits and m_tready is low; ticks then stall and
// the bus state does not advance.
// Requests arriving while a transaction or write wait runs are ignored.
// Reset (rst, synchronous) returns the sequencer to idle, clears the result
// valid flag and restores the register defaults. Registers are written over
// the APB port at byte address 4*index and should only change while idle.
module i2c_eeprom_byte_master_unit #(
  parameter int unsigned ADDRESS_BITS = i2cee_pkg::ADDRESS_BITS_DEF
) (
  input  wire  logic                              clk,
  input  wire  logic                              rst,
  // s_tdata: mem_address[15:0], write_value[23:16], sda_sample[24], zero pad
  input  wire  logic                              s_tvalid,
  output logic                                    s_tready,
  input  wire  logic [i2cee_pkg::IN_DATA_W-1:0]   s_tdata,
  // s_tuser: kind[1:0]
  input  wire  logic [i2cee_pkg::IN_USER_W-1:0]   s_tuser,
  // m_tdata: scl_level[0], sda_pull_low[1], busy_res[2], done_res[3],
  //          read_value[11:4], ack_error[12], zero pad
  output logic                                    m_tvalid,
  input  wire  logic                              m_tready,
  output logic [i2cee_pkg::OUT_DATA_W-1:0]        m_tdata,
  input  wire  logic                              psel,
  input  wire  logic                              penable,
  input  wire  logic                              pwrite,
  input  wire  logic [i2cee_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire  logic [i2cee_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [i2cee_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                    pready
);
  import i2cee_pkg::*;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_START   = 4'd1;
  localparam logic [3:0] PH_DEVW    = 4'd2;
  localparam logic [3:0] PH_ADHI    = 4'd3;
  localparam logic [3:0] PH_ADLO    = 4'd4;
  localparam logic [3:0] PH_DATA    = 4'd5;
  localparam logic [3:0] PH_RESTART = 4'd6;
  localparam logic [3:0] PH_DEVR    = 4'd7;
  localparam logic [3:0] PH_READ    = 4'd8;
  localparam logic [3:0] PH_STOP    = 4'd9;
  localparam logic [3:0] PH_WAIT    = 4'd10;

  // Configuration registers
  logic        two_byte_address;
  logic [6:0]  device_code;
  logic [7:0]  ack_timeout;
  logic [15:0] write_wait_ticks;

  // Sequencer state
  logic [3:0]              phase, phase_next;
  logic [1:0]              quarter_count, quarter_count_next;
  logic [3:0]              bit_count, bit_count_next;
  logic [7:0]              shift_byte, shift_byte_next;
  logic [7:0]              timeout_count, timeout_count_next;
  logic [15:0]             wait_count, wait_count_next;
  logic [ADDRESS_BITS-1:0] held_address, held_address_next;
  logic [7:0]              held_value, held_value_next;
  logic                    is_read, is_read_next;
  logic                    error_seen, error_seen_next;

  // Tick fields
  kind_t                 kind;
  logic [MEM_ADDR_W-1:0] mem_address;
  logic [7:0]            write_value;
  logic                  sda_sample;

  logic        scl_level, sda_pull_low, busy_res, done_res, ack_error;
  logic [7:0]  read_value;
  logic [15:0] addr_full;
  logic [7:0]  dev_byte;
  logic        in_xfer, cfg_write;
  reg_index_t  cfg_index;

  assign kind        = s_tuser[1:0];
  assign mem_address = s_tdata[15:0];
  assign write_value = s_tdata[23:16];
  assign sda_sample  = s_tdata[24];

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  assign addr_full = 16'(held_address);
  assign dev_byte  = two_byte_address ? {device_code, 1'b0}
                                      : ({device_code, 1'b0} | {4'b0, addr_full[10:8], 1'b0});

  always_comb begin
    phase_next         = phase;
    quarter_count_next = quarter_count;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    timeout_count_next = timeout_count;
    wait_count_next    = wait_count;
    held_address_next  = held_address;
    held_value_next    = held_value;
    is_read_next       = is_read;
    error_seen_next    = error_seen;
    scl_level          = 1'b1;
    sda_pull_low       = 1'b0;
    done_res           = 1'b0;

    case (phase)
      PH_IDLE: begin
        if (kind == KIND_WRITE || kind == KIND_READ) begin
          held_address_next  = mem_address[ADDRESS_BITS-1:0];
          held_value_next    = write_value;
          is_read_next       = (kind == KIND_READ);
          error_seen_next    = 1'b0;
          phase_next         = PH_START;
          quarter_count_next = 2'd0;
        end
      end
      PH_START, PH_RESTART: begin
        scl_level    = (quarter_count == 2'd1) || (quarter_count == 2'd2);
        sda_pull_low = quarter_count[1];
        if (quarter_count == 2'd3) begin
          phase_next         = (phase == PH_START) ? PH_DEVW : PH_DEVR;
          shift_byte_next    = dev_byte | {7'b0, phase == PH_RESTART};
          bit_count_next     = 4'd0;
          quarter_count_next = 2'd0;
          timeout_count_next = 8'd0;
        end else begin
          quarter_count_next = quarter_count + 2'd1;
        end
      end
      PH_DEVW, PH_ADHI, PH_ADLO, PH_DATA, PH_DEVR: begin
        scl_level = quarter_count[1];
        if (bit_count < 4'd8) begin
          sda_pull_low = !shift_byte[7];
          if (quarter_count == 2'd3) begin
            shift_byte_next    = {shift_byte[6:0], 1'b0};
            bit_count_next     = bit_count + 4'd1;
            timeout_count_next = 8'd0;
          end
          quarter_count_next = quarter_count + 2'd1;
        end else if (quarter_count == 2'd2) begin
          // Hold the sampling quarter while the slave has not acknowledged
          if (sda_sample) begin
            if (timeout_count >= ack_timeout) begin
              error_seen_next    = 1'b1;
              phase_next         = PH_STOP;
              quarter_count_next = 2'd0;
            end else begin
              timeout_count_next = timeout_count + 8'd1;
            end
          end else begin
            quarter_count_next = 2'd3;
          end
        end else if (quarter_count == 2'd3) begin
          // Acknowledged: load the next byte of the sequence, or go on to the repeated start or the stop
          bit_count_next     = 4'd0;
          quarter_count_next = 2'd0;
          timeout_count_next = 8'd0;
          case (phase)
            PH_DEVW: begin
              if (two_byte_address) begin
                phase_next      = PH_ADHI;
                shift_byte_next = addr_full[15:8];
              end else begin
                phase_next      = PH_ADLO;
                shift_byte_next = addr_full[7:0];
              end
            end
            PH_ADHI: begin
              phase_next      = PH_ADLO;
              shift_byte_next = addr_full[7:0];
            end
            PH_ADLO: begin
              if (is_read) begin
                phase_next         = PH_RESTART;
                bit_count_next     = bit_count;
                timeout_count_next = timeout_count;
              end else begin
                phase_next      = PH_DATA;
                shift_byte_next = held_value;
              end
            end
            PH_DEVR: begin
              phase_next      = PH_READ;
              shift_byte_next = 8'd0;
            end
            default: begin
              phase_next         = PH_STOP;
              bit_count_next     = bit_count;
              timeout_count_next = timeout_count;
            end
          endcase
        end else begin
          quarter_count_next = quarter_count + 2'd1;
        end
      end
      PH_READ: begin
        scl_level = quarter_count[1];
        if (bit_count < 4'd8) begin
          if (quarter_count == 2'd2) begin
            shift_byte_next = {shift_byte[6:0], sda_sample};
          end
          if (quarter_count == 2'd3) begin
            bit_count_next = bit_count + 4'd1;
          end
          quarter_count_next = quarter_count + 2'd1;
        end else if (quarter_count == 2'd3) begin
          held_value_next    = shift_byte;
          phase_next         = PH_STOP;
          quarter_count_next = 2'd0;
        end else begin
          quarter_count_next = quarter_count + 2'd1;
        end
      end
      PH_STOP: begin
        scl_level    = (quarter_count != 2'd0);
        sda_pull_low = (quarter_count != 2'd3);
        if (quarter_count == 2'd3) begin
          quarter_count_next = 2'd0;
          if (is_read || error_seen) begin
            phase_next = PH_IDLE;
            done_res   = 1'b1;
          end else begin
            phase_next      = PH_WAIT;
            wait_count_next = write_wait_ticks;
          end
        end else begin
          quarter_count_next = quarter_count + 2'd1;
        end
      end
      PH_WAIT: begin
        if (wait_count == 16'd0) begin
          phase_next = PH_IDLE;
          done_res   = 1'b1;
        end else begin
          wait_count_next = wait_count - 16'd1;
        end
      end
      default: begin
        phase_next         = PH_IDLE;
        quarter_count_next = 2'd0;
      end
    endcase
  end

  assign busy_res   = (phase_next != PH_IDLE);
  assign read_value = (done_res && is_read && !error_seen) ? held_value : 8'd0;
  assign ack_error  = done_res && error_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      quarter_count <= 2'd0;
      bit_count     <= 4'd0;
      shift_byte    <= 8'd0;
      timeout_count <= 8'd0;
      wait_count    <= 16'd0;
      held_address  <= '0;
      held_value    <= 8'd0;
      is_read       <= 1'b0;
      error_seen    <= 1'b0;
    end else if (in_xfer) begin
      phase         <= phase_next;
      quarter_count <= quarter_count_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      timeout_count <= timeout_count_next;
      wait_count    <= wait_count_next;
      held_address  <= held_address_next;
      held_value    <= held_value_next;
      is_read       <= is_read_next;
      error_seen    <= error_seen_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tdata <= {3'b0, ack_error, read_value, done_res, busy_res, sda_pull_low, scl_level};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      two_byte_address <= TWO_BYTE_ADDRESS_RST;
      device_code      <= DEVICE_CODE_RST;
      ack_timeout      <= ACK_TIMEOUT_RST;
      write_wait_ticks <= WRITE_WAIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TWO_BYTE_ADDRESS: two_byte_address <= pwdata[0];
        REG_DEVICE_CODE:      device_code      <= pwdata[6:0];
        REG_ACK_TIMEOUT:      ack_timeout      <= pwdata[7:0];
        REG_WRITE_WAIT_TICKS: write_wait_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_TWO_BYTE_ADDRESS: prdata = {31'b0, two_byte_address};
      REG_DEVICE_CODE:      prdata = {25'b0, device_code};
      REG_ACK_TIMEOUT:      prdata = {24'b0, ack_timeout};
      REG_WRITE_WAIT_TICKS: prdata = {16'b0, write_wait_ticks};
      default:              prdata = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_result_after_tick: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> m_tvalid)
    else $error("accepted tick left no result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
    else $error("done reported while still busy");

  a_error_with_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[12] || m_tdata[11:4] != 8'd0)) |-> m_tdata[3])
    else $error("error or read byte reported without done");
`endif

endmodule

`default_nettype wire

>>> tb/i2c_eeprom_byte_master_unit_tb.sv
`default_nettype none

module i2c_eeprom_byte_master_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cee_pkg::*;

  localparam kind_t KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int ITEM_TARGET = 750;
  localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDRESS_BITS_DEF) - 1);

  // Same layout as m_tdata
  typedef struct packed {
    logic [2:0] pad;
    logic       ack_error;
    logic [7:0] read_value;
    logic       done;
    logic       busy;
    logic       pull;
    logic       scl;
  } tick_result_t;

  typedef enum logic [4:0] {
    BUS_IDLE, BUS_START, BUS_DEVW, BUS_ADHI, BUS_ADLO, BUS_DATA,
    BUS_RESTART, BUS_DEVR, BUS_READ, BUS_STOP, BUS_WAIT
  } bus_phase_e;

  // How the emulated EEPROM answers on SDA
  typedef enum int {
    SDA_ZEROS, SDA_ONES, SDA_NOACK, SDA_NACK_ADDR, SDA_RANDOM
  } sda_mode_e;

  typedef struct {
    bit           two_byte;
    bit [6:0]     dev;
    bit [7:0]     ato;
    bit [15:0]    wwait;
    kind_t        kind;
    bit [15:0]    addr;
    bit [7:0]     wval;
    sda_mode_e    mode;
    bit           noise;
    bit           chk;
    tick_result_t typed;
  } op_row_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // s_tdata: mem_address[15:0], write_value[23:16], sda_sample[24], zero pad
  logic [IN_DATA_W-1:0] s_tdata = '0;
  // s_tuser: kind[1:0]
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // m_tdata: scl_level[0], sda_pull_low[1], busy_res[2], done_res[3],
  //          read_value[11:4], ack_error[12], zero pad
  logic [OUT_DATA_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  i2c_eeprom_byte_master_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register shadow
  logic        cfg_two_byte;
  logic [6:0]  cfg_dev;
  logic [7:0]  cfg_ato;
  logic [15:0] cfg_ww;

  // Bus sequencer state
  bus_phase_e  bus_ph;
  logic [1:0]  qtr;
  logic [3:0]  bit_no;
  logic [7:0]  shreg;
  logic [7:0]  ack_wait;
  logic [15:0] hold_left;
  logic [15:0] latched_addr;
  logic [7:0]  latched_byte;
  logic        op_is_read;
  logic        op_failed;

  tick_result_t results_due[$];
  int fail_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  bit send_calm = 1'b0;
  tick_result_t want, got;

  function automatic void bus_reset();
    cfg_two_byte = TWO_BYTE_ADDRESS_RST;
    cfg_dev = DEVICE_CODE_RST;
    cfg_ato = ACK_TIMEOUT_RST;
    cfg_ww = WRITE_WAIT_RST;
    bus_ph = BUS_IDLE;
    qtr = '0;
    bit_no = '0;
    shreg = '0;
    ack_wait = '0;
    hold_left = '0;
    latched_addr = '0;
    latched_byte = '0;
    op_is_read = 1'b0;
    op_failed = 1'b0;
  endfunction

  function automatic void load_byte(bus_phase_e ph, logic [7:0] b);
    bus_ph = ph;
    shreg = b;
    bit_no = '0;
    qtr = '0;
    ack_wait = '0;
  endfunction

  function automatic logic [7:0] dev_byte();
    logic [7:0] b;
    b = {cfg_dev, 1'b0};
    // one-byte addressing folds address bits 10..8 into the device byte
    if (!cfg_two_byte) b = b | {4'b0, latched_addr[10:8], 1'b0};
    return b;
  endfunction

  function automatic void next_byte();
    case (bus_ph)
      BUS_DEVW: begin
        if (cfg_two_byte) load_byte(BUS_ADHI, latched_addr[15:8]);
        else load_byte(BUS_ADLO, latched_addr[7:0]);
      end
      BUS_ADHI: load_byte(BUS_ADLO, latched_addr[7:0]);
      BUS_ADLO: begin
        if (op_is_read) begin
          bus_ph = BUS_RESTART;
          qtr = '0;
        end else begin
          load_byte(BUS_DATA, latched_byte);
        end
      end
      BUS_DEVR: load_byte(BUS_READ, 8'h00);
      default: begin
        bus_ph = BUS_STOP;
        qtr = '0;
      end
    endcase
  endfunction

  function automatic void step_bus(kind_t kind, logic [15:0] addr, logic [7:0] val,
                                   logic sda, output tick_result_t r);
    logic scl, pull, done;
    scl = 1'b1;
    pull = 1'b0;
    done = 1'b0;
    case (bus_ph)
      BUS_IDLE: begin
        if (kind == KIND_WRITE || kind == KIND_READ) begin
          latched_addr = addr & ADDR_MASK;
          latched_byte = val;
          op_is_read = (kind == KIND_READ);
          op_failed = 1'b0;
          bus_ph = BUS_START;
          qtr = '0;
        end
      end
      BUS_START, BUS_RESTART: begin
        scl = (qtr == 2'd1 || qtr == 2'd2);
        pull = (qtr >= 2'd2);
        if (qtr == 2'd3) begin
          if (bus_ph == BUS_START) load_byte(BUS_DEVW, dev_byte());
          else load_byte(BUS_DEVR, dev_byte() | 8'h01);
        end else begin
          qtr = qtr + 2'd1;
        end
      end
      BUS_DEVW, BUS_ADHI, BUS_ADLO, BUS_DATA, BUS_DEVR: begin
        scl = (qtr >= 2'd2);
        if (bit_no < 4'd8) begin
          pull = !shreg[7];
          if (qtr == 2'd3) begin
            shreg = shreg << 1;
            bit_no = bit_no + 4'd1;
            ack_wait = '0;
          end
          qtr = qtr + 2'd1;
        end else if (qtr == 2'd2) begin
          // hold the sampling quarter while SDA stays high
          if (sda) begin
            if (ack_wait >= cfg_ato) begin
              op_failed = 1'b1;
              bus_ph = BUS_STOP;
              qtr = '0;
            end else begin
              ack_wait = ack_wait + 8'd1;
            end
          end else begin
            qtr = 2'd3;
          end
        end else if (qtr == 2'd3) begin
          next_byte();
        end else begin
          qtr = qtr + 2'd1;
        end
      end
      BUS_READ: begin
        scl = (qtr >= 2'd2);
        if (bit_no < 4'd8) begin
          if (qtr == 2'd2) shreg = {shreg[6:0], sda};
          if (qtr == 2'd3) bit_no = bit_no + 4'd1;
          qtr = qtr + 2'd1;
        end else if (qtr == 2'd3) begin
          latched_byte = shreg;
          bus_ph = BUS_STOP;
          qtr = '0;
        end else begin
          qtr = qtr + 2'd1;
        end
      end
      BUS_STOP: begin
        scl = (qtr >= 2'd1);
        pull = (qtr < 2'd3);
        if (qtr == 2'd3) begin
          qtr = '0;
          if (op_is_read || op_failed) begin
            bus_ph = BUS_IDLE;
            done = 1'b1;
          end else begin
            bus_ph = BUS_WAIT;
            hold_left = cfg_ww;
          end
        end else begin
          qtr = qtr + 2'd1;
        end
      end
      BUS_WAIT: begin
        if (hold_left == 16'd0) begin
          bus_ph = BUS_IDLE;
          done = 1'b1;
        end else begin
          hold_left = hold_left - 16'd1;
        end
      end
      default: begin
        bus_ph = BUS_IDLE;
        qtr = '0;
      end
    endcase
    r = '0;
    r.scl = scl;
    r.pull = pull;
    r.busy = (bus_ph != BUS_IDLE);
    r.done = done;
    r.read_value = (done && op_is_read && !op_failed) ? latched_byte : 8'h00;
    r.ack_error = done & op_failed;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic pick_sda(sda_mode_e mode);
    bit ack_slot;
    ack_slot = (bus_ph == BUS_DEVW || bus_ph == BUS_ADHI || bus_ph == BUS_ADLO ||
                bus_ph == BUS_DATA || bus_ph == BUS_DEVR) && bit_no == 4'd8 && qtr == 2'd2;
    case (mode)
      SDA_ZEROS: return 1'b0;
      SDA_ONES: return !ack_slot;
      SDA_NOACK: return 1'b1;
      SDA_NACK_ADDR: return ack_slot ? (bus_ph != BUS_DEVW) : 1'($urandom);
      default: return ack_slot ? ($urandom_range(0, 3) == 0) : 1'($urandom);
    endcase
  endfunction

  task automatic send_tick(kind_t kind, logic [15:0] addr, logic [7:0] val, logic sda,
                           output tick_result_t r);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, sda, val, addr};
    s_tuser <= kind;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    step_bus(kind, addr, val, sda, r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(reg_index_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TWO_BYTE_ADDRESS: cfg_two_byte = val[0];
      REG_DEVICE_CODE: cfg_dev = val[6:0];
      REG_ACK_TIMEOUT: cfg_ato = val[7:0];
      default: cfg_ww = val[15:0];
    endcase
  endtask

  task automatic apply_cfg(bit tb, bit [6:0] dev, bit [7:0] ato, bit [15:0] ww,
                           bit force_all);
    if (force_all || tb != cfg_two_byte || dev != cfg_dev || ato != cfg_ato ||
        ww != cfg_ww) begin
      drain_results();
      repeat (4) @(posedge clk);
      if (force_all || tb != cfg_two_byte) set_reg(REG_TWO_BYTE_ADDRESS, 32'(tb));
      if (force_all || dev != cfg_dev) set_reg(REG_DEVICE_CODE, 32'(dev));
      if (force_all || ato != cfg_ato) set_reg(REG_ACK_TIMEOUT, 32'(ato));
      if (force_all || ww != cfg_ww) set_reg(REG_WRITE_WAIT_TICKS, 32'(ww));
    end
  endtask

  // Issue one tick, then further ticks (plain, or of random kind with noise) until the transaction ends.
  task automatic run_op(kind_t kind, logic [15:0] addr, logic [7:0] val, sda_mode_e mode,
                        bit noise, bit chk, tick_result_t typed);
    tick_result_t r;
    kind_t k;
    send_calm = ($urandom_range(0, 3) == 0);
    send_tick(kind, addr, val, pick_sda(mode), r);
    if (chk && (r.done || bus_ph == BUS_IDLE)) r = typed;
    results_due.push_back(r);
    while (bus_ph != BUS_IDLE) begin
      // stall the sender until the result stream has caught up
      if ($urandom_range(0, 299) == 0) drain_results();
      k = noise ? kind_t'($urandom_range(0, 3)) : KIND_TICK;
      send_tick(k, 16'($urandom), 8'($urandom), pick_sda(mode), r);
      if (chk && r.done) r = typed;
      results_due.push_back(r);
    end
  endtask

  op_row_t plan [0:5] = '{
    '{0, 7'h50, 8'd250, 16'd3000, KIND_TICK,  16'h0000, 8'h00, SDA_ZEROS,     0, 1, 16'h0001},
    '{0, 7'h50, 8'd250, 16'd3000, KIND_SPARE, 16'hFFFF, 8'hFF, SDA_ONES,      0, 1, 16'h0001},
    '{0, 7'h50, 8'd250, 16'd3000, KIND_READ,  16'h0000, 8'h00, SDA_ONES,      0, 1, 16'h0FF9},
    '{0, 7'h50, 8'd250, 16'd0,    KIND_WRITE, 16'h0000, 8'h00, SDA_ZEROS,     0, 1, 16'h0009},
    '{0, 7'h00, 8'd1,   16'd0,    KIND_WRITE, 16'h0500, 8'hA5, SDA_NOACK,     0, 1, 16'h1009},
    '{1, 7'h50, 8'd3,   16'd0,    KIND_READ,  16'h1234, 8'h00, SDA_NACK_ADDR, 0, 1, 16'h1009}
  };

  initial begin : recv
    int stall_left, calm_left;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 63) == 0) calm_left = $urandom_range(50, 200);
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result transfer %04h", m_tdata);
      end else begin
        want = results_due.pop_front();
        if (got.scl !== want.scl || got.pull !== want.pull || got.busy !== want.busy ||
            got.done !== want.done || got.read_value !== want.read_value ||
            got.ack_error !== want.ack_error || got.pad !== want.pad) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: want scl=%0b pull=%0b busy=%0b done=%0b rd=%02h err=%0b",
                     want.scl, want.pull, want.busy, want.done, want.read_value,
                     want.ack_error, "  got scl=%0b pull=%0b busy=%0b done=%0b rd=%02h err=%0b",
                     got.scl, got.pull, got.busy, got.done, got.read_value, got.ack_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : main
    kind_t k;
    int r;
    sda_mode_e m;
    bus_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(plan); i++) begin
      apply_cfg(plan[i].two_byte, plan[i].dev, plan[i].ato, plan[i].wwait, 1'b0);
      run_op(plan[i].kind, plan[i].addr, plan[i].wval, plan[i].mode, plan[i].noise,
             plan[i].chk, plan[i].typed);
    end

    for (int ph = 0; ph < 8 && items_sent < ITEM_TARGET; ph++) begin
      apply_cfg(ph[0],
                ph == 1 ? 7'h00 : ph == 2 ? 7'h7F : 7'($urandom),
                ph == 3 ? 8'd1 : ph == 4 ? 8'd255 : 8'($urandom_range(1, 255)),
                ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 400))
                                            : 16'($urandom_range(0, 8)),
                1'b1);
      for (int n = 0; n < 6 && items_sent < ITEM_TARGET; n++) begin
        // idle ticks between transactions
        repeat ($urandom_range(0, 3))
          run_op($urandom_range(0, 1) ? KIND_SPARE : KIND_TICK, 16'($urandom),
                 8'($urandom), SDA_RANDOM, 1'b0, 1'b0, '0);
        r = $urandom_range(0, 99);
        k = (r < 48) ? KIND_WRITE : KIND_READ;
        r = $urandom_range(0, 99);
        m = (r < 70) ? SDA_RANDOM : (r < 80) ? SDA_ZEROS : (r < 90) ? SDA_ONES :
            (r < 95) ? SDA_NOACK : SDA_NACK_ADDR;
        run_op(k, 16'($urandom), 8'($urandom), m, 1'($urandom), 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
